// ===== hw/rtl/eta_pkg.sv =====
// ----------------------------------------------------------------------------
// eta_pkg: shared types and constants of the throttle arbiter
// Holds item kinds, register indexes, pulse-width constants and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package eta_pkg;

	localparam int TimeBitsDefault = 32;
	localparam int CfgWidth = 16;
	localparam int CfgIdxWidth = 3;

	localparam logic [10:0] Neutral = 11'd1500;
	localparam logic [10:0] WidthMin = 11'd1000;
	localparam logic [10:0] WidthMax = 11'd2000;
	localparam logic [11:0] RadioLowCentre = 12'd1450;
	localparam logic [11:0] RadioHighCentre = 12'd1550;
	localparam logic [11:0] RadioGlitchLow = 12'd900;
	localparam logic [11:0] RadioGlitchHigh = 12'd2100;
	localparam logic [9:0] RadioLossMs = 10'd500;
	localparam logic [7:0] RadioCountMax = 8'd255;
	localparam logic [7:0] RadioTakeover = 8'd3;

	typedef enum logic [2:0] {
		KIND_TICK = 3'd0,
		KIND_THROTTLE = 3'd1,
		KIND_BOOST = 3'd2,
		KIND_ESTOP = 3'd3,
		KIND_RADIO = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_DEADBAND = 3'd0,
		REG_REV_NEUTRAL = 3'd1,
		REG_ESTOP_LATCH = 3'd2,
		REG_HOST_TIMEOUT = 3'd3,
		REG_BOOST_RAMP = 3'd4,
		REG_BOOST_HOLD = 3'd5,
		REG_FWD_LIMIT = 3'd6,
		REG_REV_LIMIT = 3'd7
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the item and evaluate all but the ramp step
		logic div_start;  // start the ramp division
		logic div_step;   // one quotient bit
		logic ramp_apply; // apply the finished ramp width
	} eta_cmd_t;

	typedef struct packed {
		logic need_div;   // the item needs the ramp division
		logic div_last;   // final quotient bit is being produced
	} eta_status_t;

	function automatic logic [10:0] clamp_width(input logic [11:0] v);
		if (v < {1'b0, WidthMin}) return WidthMin;
		if (v > {1'b0, WidthMax}) return WidthMax;
		return v[10:0];
	endfunction

endpackage

// ===== hw/rtl/esc_throttle_arbiter_core.sv =====
// An accepted item passes the states IDLE, EVAL and OUT before its result beat;
// a boost ramp step adds the DIV state for the bit-serial ramp division.
// Items are handled one at a time; a new one is taken only in IDLE with the output free.
// Reset: arst_n clears control and arbiter state asynchronously; configuration
// registers return to their defaults. Captured item and divider are not reset.
// ----------------------------------------------------------------------------
// esc_throttle_arbiter_core: throttle arbiter for a motor speed controller
// Chooses the drive pulse width between host commands and a radio receiver.
// ----------------------------------------------------------------------------
module esc_throttle_arbiter_core
	import eta_pkg::*;
#(
	parameter int TIME_BITS = TimeBitsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_idx,
	input  logic [CfgWidth-1:0]    cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             kind,
	input  logic [11:0]            value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [10:0]            pulse_out,
	output logic                   radio_mode,
	output logic                   estop_active,
	output logic                   boost_running,
	output logic                   reverse_hold
);

	eta_cmd_t cmd;
	eta_status_t status;

	eta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
	);

	eta_datapath #(.TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .kind(kind), .value(value), .cmd(cmd), .status(status),
		.pulse_out(pulse_out), .radio_mode(radio_mode), .estop_active(estop_active),
		.boost_running(boost_running), .reverse_hold(reverse_hold)
	);

endmodule

// ===== hw/rtl/eta_ctrl.sv =====
// ----------------------------------------------------------------------------
// eta_ctrl: sequencing controller of the throttle arbiter
// Accepts an item, runs the ramp divider when needed and presents the beat.
// ----------------------------------------------------------------------------
module eta_ctrl
	import eta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output eta_cmd_t    cmd,
	input  eta_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;
	logic out_valid_q;

	// The output register is free once its beat is taken; a new item may then enter.
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid && out_free;
			ST_EVAL: cmd.div_start = status.need_div;
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.ramp_apply = status.div_last;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	// A beat is only pending in the idle state, so the output register is empty
	// whenever an item is in work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && !out_stall)
						out_valid_q <= 1'b0;
					if (in_valid && out_free) state_q <= ST_EVAL;
				end
				ST_EVAL: state_q <= status.need_div ? ST_DIV : ST_OUT;
				ST_DIV: if (status.div_last) state_q <= ST_OUT;
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/eta_datapath.sv =====
// ----------------------------------------------------------------------------
// eta_datapath: state, arbitration and ramp divider of the throttle arbiter
// Holds every state register and evaluates one item under controller command.
// ----------------------------------------------------------------------------
module eta_datapath
	import eta_pkg::*;
#(
	parameter int TIME_BITS = TimeBitsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_idx,
	input  logic [CfgWidth-1:0]    cfg_data,
	input  logic [2:0]             kind,
	input  logic [11:0]            value,
	input  eta_cmd_t               cmd,
	output eta_status_t            status,
	output logic [10:0]            pulse_out,
	output logic                   radio_mode,
	output logic                   estop_active,
	output logic                   boost_running,
	output logic                   reverse_hold
);

	localparam int TB = TIME_BITS;

	// configuration
	logic [8:0]  deadband_q;
	logic [15:0] rev_neutral_q, estop_latch_q, host_timeout_q, ramp_q, hold_q;
	logic [10:0] fwd_limit_q, rev_limit_q;

	// state
	logic [TB-1:0] now_q, host_last_q, estop_until_q, rev_release_q;
	logic [TB-1:0] boost_start_q, radio_last_q;
	logic          radio_sel_q, rev_pend_q, boost_act_q, radio_fresh_q;
	logic [10:0]   host_thr_q, boost_base_q, boost_peak_q, drive_q;
	logic [1:0]    applied_dir_q;
	logic [11:0]   radio_width_q;
	logic [7:0]    radio_cnt_q;

	// divider: |off| * el / ramp, el < ramp <= 65535
	logic [26:0] div_rem_q;
	logic [26:0] div_num_q;
	logic [26:0] div_quo_q;
	logic [4:0]  div_cnt_q;
	logic        div_neg_q;

	// items captured on load
	logic [2:0]  kind_q;
	logic [11:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= 9'd50;
			rev_neutral_q <= 16'd200;
			estop_latch_q <= 16'd1000;
			host_timeout_q <= 16'd2500;
			ramp_q <= 16'd250;
			hold_q <= 16'd800;
			fwd_limit_q <= 11'd1900;
			rev_limit_q <= 11'd1100;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_DEADBAND: deadband_q <= cfg_data[8:0];
				REG_REV_NEUTRAL: rev_neutral_q <= cfg_data;
				REG_ESTOP_LATCH: estop_latch_q <= cfg_data;
				REG_HOST_TIMEOUT: host_timeout_q <= cfg_data;
				REG_BOOST_RAMP: ramp_q <= cfg_data;
				REG_BOOST_HOLD: hold_q <= cfg_data;
				REG_FWD_LIMIT: fwd_limit_q <= cfg_data[10:0];
				REG_REV_LIMIT: rev_limit_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			value_q <= value;
		end
	end

	// Working copy of the state, passed through the item's evaluation.
	typedef struct packed {
		logic [TB-1:0] now, host_last, estop_until, rev_release, boost_start, radio_last;
		logic          radio_sel, rev_pend, boost_act, radio_fresh;
		logic [10:0]   host_thr, boost_base, boost_peak, drive;
		logic [1:0]    dir;
		logic [11:0]   radio_width;
		logic [7:0]    radio_cnt;
	} st_t;

	function automatic logic [1:0] dir_of(input logic [10:0] w, input logic [8:0] db);
		if ({1'b0, w} > {1'b0, Neutral} + {3'b0, db}) return 2'b01;
		if ({1'b0, w} + {3'b0, db} < {1'b0, Neutral}) return 2'b11;
		return 2'b00;
	endfunction

	function automatic st_t force_neutral(input st_t s);
		st_t r;
		r = s;
		r.boost_act = 1'b0;
		r.rev_pend = 1'b0;
		r.dir = 2'b00;
		r.drive = Neutral;
		return r;
	endfunction

	function automatic st_t cancel_boost(input st_t s);
		st_t r;
		r = s;
		r.boost_act = 1'b0;
		r.boost_base = Neutral;
		r.boost_peak = Neutral;
		r.boost_start = '0;
		return r;
	endfunction

	function automatic st_t request_output(input st_t s, input logic [11:0] w,
			input logic [8:0] db, input logic [15:0] rn);
		st_t r;
		logic [10:0] tgt;
		logic [1:0] d;
		r = s;
		tgt = clamp_width(w);
		d = dir_of(tgt, db);
		if (r.rev_pend) begin
			if (d == 2'b00) return force_neutral(r);
			if (r.now < r.rev_release) begin
				r.drive = Neutral;
				return r;
			end
			r.rev_pend = 1'b0;
		end
		if (d != 2'b00 && r.dir != 2'b00 && d != r.dir) begin
			r.rev_pend = 1'b1;
			r.rev_release = r.now + TB'(rn);
			r.dir = 2'b00;
			r.drive = Neutral;
			return r;
		end
		r.drive = tgt;
		r.dir = d;
		return r;
	endfunction

	st_t cur, nxt, ramp_nxt;
	logic need_div;
	logic [TB-1:0] el;
	logic [10:0] ramp_mag;
	logic ramp_neg;

	always_comb begin
		cur.now = now_q; cur.host_last = host_last_q; cur.estop_until = estop_until_q;
		cur.rev_release = rev_release_q; cur.boost_start = boost_start_q;
		cur.radio_last = radio_last_q; cur.radio_sel = radio_sel_q;
		cur.rev_pend = rev_pend_q; cur.boost_act = boost_act_q;
		cur.radio_fresh = radio_fresh_q; cur.host_thr = host_thr_q;
		cur.boost_base = boost_base_q; cur.boost_peak = boost_peak_q;
		cur.drive = drive_q; cur.dir = applied_dir_q;
		cur.radio_width = radio_width_q; cur.radio_cnt = radio_cnt_q;
	end

	// Evaluation of one item. A boost ramp step leaves its width to the divider.
	always_comb begin
		logic [10:0] req, dmag;
		logic [11:0] mag, boosted;
		logic [12:0] peak;
		logic keep, alive;
		nxt = cur;
		need_div = 1'b0;
		el = '0;
		ramp_mag = '0;
		ramp_neg = 1'b0;
		req = '0; dmag = '0; mag = '0; boosted = '0; peak = '0;
		keep = 1'b0; alive = 1'b0;
		case (kind_q)
			KIND_TICK: begin
				nxt.now = cur.now + 1'b1;
				alive = (nxt.now - nxt.radio_last) < TB'(RadioLossMs);
				if (nxt.now < nxt.estop_until) begin
					nxt = force_neutral(nxt);
					nxt.radio_cnt = '0;
				end else begin
					if (alive) begin
						if (nxt.radio_fresh) begin
							nxt.radio_fresh = 1'b0;
							if (nxt.radio_width < RadioLowCentre
									|| nxt.radio_width > RadioHighCentre) begin
								if (nxt.radio_cnt != RadioCountMax)
									nxt.radio_cnt = nxt.radio_cnt + 1'b1;
								if (nxt.radio_cnt > RadioTakeover && !nxt.radio_sel) begin
									nxt.radio_sel = 1'b1;
									nxt = cancel_boost(nxt);
								end
							end else begin
								nxt.radio_cnt = '0;
							end
						end
						if (nxt.radio_sel)
							nxt = request_output(nxt, nxt.radio_width, deadband_q,
								rev_neutral_q);
					end else begin
						if (nxt.radio_sel) begin
							nxt.radio_sel = 1'b0;
							nxt.host_thr = Neutral;
							nxt = force_neutral(nxt);
						end
						nxt.radio_cnt = '0;
					end
					if (!nxt.radio_sel && nxt.boost_act) begin
						el = nxt.now - nxt.boost_start;
						if (el < TB'(ramp_q)) begin
							// Ramp step: the divider finishes it, timeout is checked there.
							need_div = 1'b1;
							ramp_neg = nxt.boost_peak < nxt.boost_base;
							ramp_mag = ramp_neg ? nxt.boost_base - nxt.boost_peak
								: nxt.boost_peak - nxt.boost_base;
						end else if ({1'b0, el} < {1'b0, TB'(ramp_q)} + {1'b0, TB'(hold_q)})
							nxt = request_output(nxt, {1'b0, nxt.boost_peak}, deadband_q,
								rev_neutral_q);
						else begin
							nxt.boost_act = 1'b0;
							nxt = request_output(nxt, {1'b0, nxt.boost_base}, deadband_q,
								rev_neutral_q);
						end
					end else if (!nxt.radio_sel && nxt.rev_pend)
						nxt = request_output(nxt, {1'b0, nxt.host_thr}, deadband_q,
							rev_neutral_q);
					if (!need_div && !nxt.radio_sel && nxt.host_thr != Neutral
							&& nxt.host_last != '0
							&& (nxt.now - nxt.host_last) > TB'(host_timeout_q)) begin
						nxt.host_thr = Neutral;
						nxt = force_neutral(nxt);
						nxt.host_last = '0;
					end
				end
			end
			KIND_THROTTLE: begin
				if (!(cur.now < cur.estop_until)) begin
					req = clamp_width(value_q);
					keep = cur.boost_act && req == cur.boost_base;
					nxt.host_thr = req;
					nxt.host_last = cur.now;
					nxt.radio_sel = 1'b0;
					if (!keep) begin
						nxt = cancel_boost(nxt);
						nxt = request_output(nxt, {1'b0, req}, deadband_q, rev_neutral_q);
					end
				end
			end
			KIND_BOOST: begin
				if (!(cur.now < cur.estop_until)) begin
					req = clamp_width(value_q);
					nxt.host_thr = req;
					nxt.host_last = cur.now;
					nxt.radio_sel = 1'b0;
					dmag = (req >= Neutral) ? req - Neutral : Neutral - req;
					if (dmag <= {2'b0, deadband_q}) begin
						nxt = cancel_boost(nxt);
						nxt = request_output(nxt, {1'b0, req}, deadband_q, rev_neutral_q);
					end else begin
						mag = {1'b0, dmag};
						boosted = 12'((({2'b0, mag} * 14'd3) + 14'd1) >> 1);
						if (req > Neutral) begin
							peak = {2'b0, Neutral} + {1'b0, boosted};
							if (peak > {2'b0, fwd_limit_q}) peak = {2'b0, fwd_limit_q};
						end else begin
							peak = {2'b0, Neutral} - {1'b0, boosted};
							if ($signed(peak) < $signed({2'b0, rev_limit_q}))
								peak = {2'b0, rev_limit_q};
						end
						nxt.boost_base = req;
						nxt.boost_peak = peak[10:0];
						nxt.boost_start = cur.now;
						nxt.boost_act = peak[10:0] != req;
						nxt = request_output(nxt, {1'b0, req}, deadband_q, rev_neutral_q);
					end
				end
			end
			KIND_ESTOP: begin
				nxt.host_thr = Neutral;
				nxt.radio_sel = 1'b0;
				nxt.estop_until = cur.now + TB'(estop_latch_q);
				nxt.host_last = '0;
				nxt = force_neutral(nxt);
			end
			KIND_RADIO: begin
				if (value_q > RadioGlitchLow && value_q < RadioGlitchHigh) begin
					nxt.radio_width = value_q;
					nxt.radio_last = cur.now;
					nxt.radio_fresh = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Ramp completion, after the quotient is known.
	always_comb begin
		logic [11:0] w;
		ramp_nxt = cur;
		w = div_neg_q ? {1'b0, cur.boost_base} - div_quo_q[11:0]
			: {1'b0, cur.boost_base} + div_quo_q[11:0];
		ramp_nxt = request_output(ramp_nxt, w, deadband_q, rev_neutral_q);
		if (!ramp_nxt.radio_sel && ramp_nxt.host_thr != Neutral
				&& ramp_nxt.host_last != '0
				&& (ramp_nxt.now - ramp_nxt.host_last) > TB'(host_timeout_q)) begin
			ramp_nxt.host_thr = Neutral;
			ramp_nxt = force_neutral(ramp_nxt);
			ramp_nxt.host_last = '0;
		end
	end

	assign status.need_div = need_div;
	assign status.div_last = (div_cnt_q == 5'd0);

	// Restoring divider, one quotient bit per cycle, MSB first.
	logic [27:0] trial;
	assign trial = {div_rem_q, div_num_q[26]} - {12'd0, ramp_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_num_q <= {16'd0, ramp_mag} * {11'd0, el[15:0]};
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_cnt_q <= 5'd26;
			div_neg_q <= ramp_neg;
		end else if (cmd.div_step) begin
			div_num_q <= {div_num_q[25:0], 1'b0};
			if (!trial[27]) begin
				div_rem_q <= trial[26:0];
				div_quo_q <= {div_quo_q[25:0], 1'b1};
			end else begin
				div_rem_q <= {div_rem_q[25:0], div_num_q[26]};
				div_quo_q <= {div_quo_q[25:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// Evaluation state is committed in the cycle after load (EVAL); a ramp step is
	// committed partly then and fully when the quotient is applied.
	logic eval_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eval_q <= 1'b0;
		else eval_q <= cmd.load;
	end

	logic ramp_apply_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ramp_apply_q <= 1'b0;
		else ramp_apply_q <= cmd.ramp_apply;
	end

	// On the apply cycle the divider register holds the full quotient.
	st_t sel;
	always_comb begin
		sel = ramp_apply_q ? ramp_nxt : nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0; host_last_q <= '0; estop_until_q <= '0;
			rev_release_q <= '0; boost_start_q <= '0; radio_last_q <= '0;
			radio_sel_q <= 1'b0; rev_pend_q <= 1'b0; boost_act_q <= 1'b0;
			radio_fresh_q <= 1'b0;
			host_thr_q <= Neutral; boost_base_q <= Neutral; boost_peak_q <= Neutral;
			drive_q <= Neutral; applied_dir_q <= 2'b00;
			radio_width_q <= {1'b0, Neutral}; radio_cnt_q <= '0;
		end else if (eval_q || ramp_apply_q) begin
			now_q <= sel.now; host_last_q <= sel.host_last;
			estop_until_q <= sel.estop_until; rev_release_q <= sel.rev_release;
			boost_start_q <= sel.boost_start; radio_last_q <= sel.radio_last;
			radio_sel_q <= sel.radio_sel; rev_pend_q <= sel.rev_pend;
			boost_act_q <= sel.boost_act; radio_fresh_q <= sel.radio_fresh;
			host_thr_q <= sel.host_thr; boost_base_q <= sel.boost_base;
			boost_peak_q <= sel.boost_peak; drive_q <= sel.drive;
			applied_dir_q <= sel.dir; radio_width_q <= sel.radio_width;
			radio_cnt_q <= sel.radio_cnt;
		end
	end

	assign pulse_out = drive_q;
	assign radio_mode = radio_sel_q;
	assign estop_active = now_q < estop_until_q;
	assign boost_running = boost_act_q;
	assign reverse_hold = rev_pend_q;

endmodule

// ===== hw/rtl/eta_checker.sv =====
// ----------------------------------------------------------------------------
// eta_checker: port-level checks of the throttle arbiter
// Watches the handshakes and result ranges seen at the top level.
// ----------------------------------------------------------------------------
module eta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [10:0] pulse_out,
	input logic        radio_mode,
	input logic        boost_running
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pulse_out))
		else $error("result beat changed while stalled");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_out >= 11'd1000 && pulse_out <= 11'd2000)
		else $error("pulse width out of range");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in work");

	a_radio_no_boost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && radio_mode |-> !boost_running)
		else $error("boost running under radio control");

endmodule

bind esc_throttle_arbiter_core eta_checker u_eta_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .pulse_out(pulse_out),
	.radio_mode(radio_mode), .boost_running(boost_running)
);

// ===== tb/sv/esc_throttle_arbiter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esc_throttle_arbiter_core_tb: self-checking bench for the throttle arbiter
// Drives ticks, host throttle and boost commands, emergency stops and receiver
// pulses in bursts, and checks every status beat against a local predictor.
// The registers are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module esc_throttle_arbiter_core_tb
	import eta_pkg::*;
();

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 40;
	localparam int NumPhases = 5;
	localparam int NumRegs = 8;
	localparam logic [2:0] KindUnusedLo = 3'd5;
	localparam logic [2:0] KindUnusedHi = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [11:0] value;
	} item_t;

	typedef struct packed {
		logic [10:0] pulse;
		logic        radio;
		logic        estop;
		logic        boost;
		logic        rev_hold;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxWidth-1:0] cfg_idx = '0;
	logic [CfgWidth-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] kind = '0;
	logic [11:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [10:0] pulse_out;
	logic radio_mode, estop_active, boost_running, reverse_hold;

	esc_throttle_arbiter_core u_top (.*);

	always #4 clk = ~clk;

	// Predictor state.
	int db_us, rev_ms, latch_ms, timeout_ms, ramp_ms, hold_ms, fwd_lim, rev_lim;
	logic [31:0] now_ms, host_last_ms, estop_until, rev_release, boost_start, radio_last;
	bit radio_sel, rev_pend, boost_act, radio_fresh;
	int host_thr, applied_dir, boost_base, boost_peak, radio_w, drive_w, radio_cnt;

	item_t stim_q[$];
	status_t status_q[$];
	int errors = 0;
	int idle_cycles = 0;

	function automatic int clamp_w(int v);
		return v < int'(WidthMin) ? int'(WidthMin) : (v > int'(WidthMax) ? int'(WidthMax) : v);
	endfunction

	function automatic int dir_of(int w);
		if (w > int'(Neutral) + db_us) return 1;
		if (w < int'(Neutral) - db_us) return -1;
		return 0;
	endfunction

	function automatic void go_neutral();
		boost_act = 0;
		rev_pend = 0;
		applied_dir = 0;
		drive_w = Neutral;
	endfunction

	function automatic void drop_boost();
		boost_act = 0;
		boost_base = Neutral;
		boost_peak = Neutral;
		boost_start = '0;
	endfunction

	function automatic void ask_output(int w);
		int tgt, d;
		tgt = clamp_w(w);
		d = dir_of(tgt);
		if (rev_pend) begin
			if (d == 0) begin
				go_neutral();
				return;
			end
			if (now_ms < rev_release) begin
				drive_w = Neutral;
				return;
			end
			rev_pend = 0;
		end
		if (d != 0 && applied_dir != 0 && d != applied_dir) begin
			rev_pend = 1;
			rev_release = now_ms + 32'(rev_ms);
			applied_dir = 0;
			drive_w = Neutral;
			return;
		end
		drive_w = tgt;
		applied_dir = d;
	endfunction

	function automatic void throttle_cmd(int v);
		int req;
		bit keep;
		req = clamp_w(v);
		keep = boost_act && req == boost_base;
		host_thr = req;
		host_last_ms = now_ms;
		radio_sel = 0;
		if (keep) return;
		drop_boost();
		ask_output(host_thr);
	endfunction

	function automatic void boost_cmd(int v);
		int delta, mag, boosted;
		host_thr = clamp_w(v);
		host_last_ms = now_ms;
		radio_sel = 0;
		delta = host_thr - int'(Neutral);
		mag = delta < 0 ? -delta : delta;
		if (mag <= db_us) begin
			drop_boost();
			ask_output(host_thr);
			return;
		end
		boosted = (3 * mag + 1) / 2;
		if (delta < 0) boosted = -boosted;
		boost_base = host_thr;
		boost_peak = int'(Neutral) + boosted;
		if (delta > 0) begin
			if (boost_peak > fwd_lim) boost_peak = fwd_lim;
		end else begin
			if (boost_peak < rev_lim) boost_peak = rev_lim;
		end
		boost_start = now_ms;
		boost_act = boost_peak != boost_base;
		ask_output(boost_base);
	endfunction

	function automatic void boost_profile();
		longint el, part;
		if (!boost_act || radio_sel) return;
		el = longint'(now_ms - boost_start);
		if (el < ramp_ms) begin
			// Division truncates toward zero, as the ramp step requires.
			part = longint'(boost_peak - boost_base) * el / longint'(ramp_ms);
			ask_output(boost_base + int'(part));
			return;
		end
		if (el < longint'(ramp_ms) + longint'(hold_ms)) begin
			ask_output(boost_peak);
			return;
		end
		boost_act = 0;
		ask_output(boost_base);
	endfunction

	function automatic void supervise_tick();
		bit rc_alive;
		rc_alive = (now_ms - radio_last) < 32'(RadioLossMs);
		if (now_ms < estop_until) begin
			go_neutral();
			radio_cnt = 0;
			return;
		end
		if (rc_alive) begin
			if (radio_fresh) begin
				radio_fresh = 0;
				if (radio_w < int'(RadioLowCentre) || radio_w > int'(RadioHighCentre)) begin
					if (radio_cnt < int'(RadioCountMax)) radio_cnt++;
					if (radio_cnt > int'(RadioTakeover) && !radio_sel) begin
						radio_sel = 1;
						drop_boost();
					end
				end else begin
					radio_cnt = 0;
				end
			end
			if (radio_sel) ask_output(radio_w);
		end else begin
			if (radio_sel) begin
				radio_sel = 0;
				host_thr = Neutral;
				go_neutral();
			end
			radio_cnt = 0;
		end
		if (!radio_sel && boost_act) boost_profile();
		else if (!radio_sel && rev_pend) ask_output(host_thr);
		if (!radio_sel && host_thr != int'(Neutral) && host_last_ms != 0 &&
				(now_ms - host_last_ms) > 32'(timeout_ms)) begin
			host_thr = Neutral;
			go_neutral();
			host_last_ms = '0;
		end
	endfunction

	function automatic status_t advance_arbiter(item_t it);
		status_t s;
		int v;
		v = it.value;
		case (it.kind)
			KIND_TICK: begin
				now_ms = now_ms + 1;
				supervise_tick();
			end
			KIND_THROTTLE: if (!(now_ms < estop_until)) throttle_cmd(v);
			KIND_BOOST: if (!(now_ms < estop_until)) boost_cmd(v);
			KIND_ESTOP: begin
				host_thr = Neutral;
				radio_sel = 0;
				estop_until = now_ms + 32'(latch_ms);
				host_last_ms = '0;
				go_neutral();
			end
			KIND_RADIO: if (v > int'(RadioGlitchLow) && v < int'(RadioGlitchHigh)) begin
				radio_w = v;
				radio_last = now_ms;
				radio_fresh = 1;
			end
			default: ;
		endcase
		s.pulse = 11'(drive_w);
		s.radio = radio_sel;
		s.estop = now_ms < estop_until;
		s.boost = boost_act;
		s.rev_hold = rev_pend;
		return s;
	endfunction

	function automatic void reset_arbiter();
		db_us = 50; rev_ms = 200; latch_ms = 1000; timeout_ms = 2500;
		ramp_ms = 250; hold_ms = 800; fwd_lim = 1900; rev_lim = 1100;
		now_ms = '0; host_last_ms = '0; estop_until = '0; rev_release = '0;
		boost_start = '0; radio_last = '0;
		radio_sel = 0; rev_pend = 0; boost_act = 0; radio_fresh = 0;
		host_thr = Neutral; applied_dir = 0; boost_base = Neutral; boost_peak = Neutral;
		radio_w = Neutral; drive_w = Neutral; radio_cnt = 0;
	endfunction

	function automatic void set_register(reg_idx_t idx, int val);
		case (idx)
			REG_DEADBAND: db_us = val & 'h1FF;
			REG_REV_NEUTRAL: rev_ms = val & 'hFFFF;
			REG_ESTOP_LATCH: latch_ms = val & 'hFFFF;
			REG_HOST_TIMEOUT: timeout_ms = val & 'hFFFF;
			REG_BOOST_RAMP: ramp_ms = val & 'hFFFF;
			REG_BOOST_HOLD: hold_ms = val & 'hFFFF;
			REG_FWD_LIMIT: fwd_lim = val & 'h7FF;
			REG_REV_LIMIT: rev_lim = val & 'h7FF;
			default: ;
		endcase
	endfunction

	initial reset_arbiter();

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		item_t nxt;
		logic nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				status_q.push_back(advance_arbiter('{kind, value}));
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() > 0) begin
					nxt = stim_q.pop_front();
					kind <= nxt.kind;
					value <= nxt.value;
					nv = 1'b1;
					if (--burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			in_valid <= nv;
		end
	end

	// Receiver: the stall style is taken from a free-running cycle counter, and one style never stalls.
	int rx_cycles = 0;
	int stall_run = 0;
	always @(posedge clk or negedge arst_n) begin
		logic ns;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			rx_cycles++;
			ns = 1'b0;
			case (rx_cycles[9:8])
				2'd1: ns = ($urandom_range(0, 3) == 0);
				2'd2: begin
					if (stall_run > 0) begin
						stall_run--;
						ns = 1'b1;
					end else if ($urandom_range(0, 5) == 0) begin
						stall_run = $urandom_range(1, 15);
					end
				end
				2'd3: ns = rx_cycles[0];
				default: ns = 1'b0;
			endcase
			out_stall <= ns;
		end
	end

	// Checker for the status beats.
	always @(posedge clk) begin
		status_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{pulse_out, radio_mode, estop_active, boost_running, reverse_hold};
			if (status_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected status beat %p", got);
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) $display("status mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles in which no item is taken.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("esc_throttle_arbiter_core_tb: done, errors");
			$finish;
		end
	end

	function automatic void add(logic [2:0] k, int v);
		stim_q.push_back('{k, 12'(v)});
	endfunction

	function automatic int pick_width();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 4095);
			1: return $urandom_range(1400, 1600);
			2: return $urandom_range(900, 1100);
			3: return $urandom_range(1900, 2100);
			default: return $urandom_range(1000, 2000);
		endcase
	endfunction

	function automatic void add_ticks(int n);
		repeat (n) add(KIND_TICK, $urandom_range(0, 4095));
	endfunction

	function automatic void random_phase(int n_items, int max_wait);
		int k;
		while (n_items > 0) begin
			k = $urandom_range(0, 99);
			if (k < 30) begin
				add(KIND_THROTTLE, pick_width());
				k = $urandom_range(1, max_wait);
				add_ticks(k);
				n_items -= k + 1;
			end else if (k < 50) begin
				add(KIND_BOOST, pick_width());
				k = $urandom_range(1, 2 * max_wait);
				add_ticks(k);
				n_items -= k + 1;
			end else if (k < 68) begin
				// A run of three to eight receiver frames with ticks; four or more can bring a takeover.
				k = $urandom_range(3, 8);
				repeat (k) begin
					add(KIND_RADIO, ($urandom_range(0, 3) == 0) ? $urandom_range(1451, 1549)
							: pick_width());
					add_ticks($urandom_range(1, 3));
				end
				n_items -= 3 * k;
			end else if (k < 72) begin
				add(KIND_ESTOP, $urandom_range(0, 4095));
				n_items--;
			end else if (k < 75) begin
				add(3'($urandom_range(KindUnusedLo, KindUnusedHi)), $urandom_range(0, 4095));
				n_items--;
			end else begin
				k = $urandom_range(1, max_wait);
				add_ticks(k);
				n_items -= k;
			end
		end
	endfunction

	task automatic wait_idle();
		while (stim_q.size() > 0 || in_valid || status_q.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_regs(int vals[NumRegs]);
		for (int i = 0; i < NumRegs; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= CfgIdxWidth'(i);
			cfg_data <= CfgWidth'(vals[i]);
			set_register(reg_idx_t'(i), vals[i]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int settings[NumPhases][NumRegs];
		settings[0] = '{50, 200, 1000, 2500, 250, 800, 1900, 1100};
		settings[1] = '{30, 5, 20, 60, 10, 15, 1800, 1200};
		settings[2] = '{0, 0, 0, 0, 1, 0, 1500, 1500};
		settings[3] = '{0, 3, 8, 40, 0, 6, 2000, 1000};
		settings[4] = '{500, 65535, 65535, 65535, 65535, 65535, 2047, 0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int p = 0; p < NumPhases; p++) begin
			write_regs(settings[p]);
			if (p == 1) begin
				// Extremes, a reversal, boosts both ways, the latch and glitches.
				add(KIND_THROTTLE, 2000); add_ticks(2);
				add(KIND_THROTTLE, 1000); add_ticks(7);
				add(KIND_THROTTLE, 4095); add(KIND_THROTTLE, 1500);
				add(KIND_BOOST, 1800); add_ticks(4);
				add(KIND_BOOST, 0); add_ticks(2);
				add(KIND_ESTOP, 0);
				add(KIND_THROTTLE, 1900); add(KIND_BOOST, 1900);
				add(KIND_RADIO, 900); add(KIND_RADIO, 2100);
				add(KIND_RADIO, 901); add(KIND_RADIO, 2099);
				add(KIND_RADIO, 4095); add(KIND_TICK, 0);
				add(KindUnusedHi, 4095);
			end
			random_phase(p == 4 ? 120 : 320, p == 0 ? 40 : 12);
			wait_idle();
		end
		if (errors == 0 && status_q.size() == 0) begin
			$display("esc_throttle_arbiter_core_tb: done, clean");
		end else begin
			$display("esc_throttle_arbiter_core_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/eta_pkg.sv
hw/rtl/eta_ctrl.sv
hw/rtl/eta_datapath.sv
hw/rtl/esc_throttle_arbiter_core.sv
hw/rtl/eta_checker.sv
tb/sv/esc_throttle_arbiter_core_tb.sv
